>>> sv/gehr_pkg.sv
// ----------------------------------------------------------------------------
// gehr_pkg
// Types, event codes and lookup functions for the gamepad HID report builder.
// ----------------------------------------------------------------------------
`default_nettype none

package gehr_pkg;

	// Event kinds
	localparam logic [1:0] KIND_KEY = 2'd0;
	localparam logic [1:0] KIND_ABS = 2'd1;

	// Code groups, Linux input numbering
	localparam logic [15:0] DPAD_BASE   = 16'h0220;
	localparam logic [15:0] BUTTON_BASE = 16'h0130;

	// Absolute axis codes
	localparam logic [15:0] ABS_X  = 16'd0;
	localparam logic [15:0] ABS_Y  = 16'd1;
	localparam logic [15:0] ABS_RX = 16'd3;
	localparam logic [15:0] ABS_RY = 16'd4;

	localparam int unsigned BUTTON_COUNT = 13;

	localparam logic [3:0] HAT_NEUTRAL = 4'd8;
	localparam logic [7:0] AXIS_MAX    = 8'hFF;

	// Dpad mask bits
	localparam int unsigned DPAD_UP    = 0;
	localparam int unsigned DPAD_DOWN  = 1;
	localparam int unsigned DPAD_LEFT  = 2;
	localparam int unsigned DPAD_RIGHT = 3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] event_code;
		logic [31:0] event_value;
	} event_t;

	typedef struct packed {
		logic [3:0]              hat_position;
		logic [BUTTON_COUNT-1:0] button_bits;
		logic [7:0]              axis_x;
		logic [7:0]              axis_y;
		logic [7:0]              axis_rx;
		logic [7:0]              axis_ry;
	} report_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] idx;
	} btn_map_t;

	// Hat code per direction mask; opposing, empty or triple masks give neutral
	function automatic logic [3:0] hat_of_mask(input logic [3:0] mask);
		logic [3:0] hat;
		case (mask)
			4'b0001: hat = 4'd0;
			4'b1001: hat = 4'd1;
			4'b1000: hat = 4'd2;
			4'b1010: hat = 4'd3;
			4'b0010: hat = 4'd4;
			4'b0110: hat = 4'd5;
			4'b0100: hat = 4'd6;
			4'b0101: hat = 4'd7;
			default: hat = HAT_NEUTRAL;
		endcase
		return hat;
	endfunction

	// Button bit per code offset from BUTTON_BASE
	function automatic btn_map_t button_of_offset(input logic [3:0] offset);
		btn_map_t m;
		m.hit = 1'b1;
		case (offset)
			4'h0: m.idx = 4'd0;
			4'h1: m.idx = 4'd1;
			4'h3: m.idx = 4'd2;
			4'h4: m.idx = 4'd3;
			4'h6: m.idx = 4'd4;
			4'h7: m.idx = 4'd5;
			4'h8: m.idx = 4'd11;
			4'h9: m.idx = 4'd12;
			4'hA: m.idx = 4'd6;
			4'hB: m.idx = 4'd7;
			4'hC: m.idx = 4'd8;
			4'hD: m.idx = 4'd9;
			4'hE: m.idx = 4'd10;
			default: begin
				m.hit = 1'b0;
				m.idx = 4'd0;
			end
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

>>> sv/gehr_event_if.sv
// ----------------------------------------------------------------------------
// gehr_event_if
// Valid/ready channel carrying one input event per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface gehr_event_if;
	import gehr_pkg::*;

	logic   valid;
	logic   ready;
	event_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> sv/gehr_report_if.sv
// ----------------------------------------------------------------------------
// gehr_report_if
// Valid/ready channel carrying one full gamepad report per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface gehr_report_if;
	import gehr_pkg::*;

	logic    valid;
	logic    ready;
	report_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> sv/gamepad_event_to_hid_report_core.sv
// ----------------------------------------------------------------------------
// gamepad_event_to_hid_report_core
// Applies input events to a held gamepad report and emits the report per event.
// ----------------------------------------------------------------------------
`default_nettype none

// Every accepted event yields exactly one report transaction holding the full
// gamepad state after that event: hat, thirteen buttons and four 8-bit stick
// axes. An event passes through two registers, the input register and then
// the report register, which builds the report from the held event; with
// the report side ready the block takes one event every cycle. The
// report register doubles as the held state, so a stalled report simply holds
// it and the input register keeps the next event until the report is taken.
// Key events on dpad codes edit a four-bit direction mask and re-encode the
// hat (0 up, clockwise to 7 up-left, 8 neutral or invalid mix); key events on
// button codes write one button bit; axis events on X, Y, RX and RY store the
// value saturated to 255. Anything else leaves the report unchanged.
module gamepad_event_to_hid_report_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	gehr_event_if.sink  evt,
	gehr_report_if.source rpt
);
	import gehr_pkg::*;

	// Input stage
	event_t     event_s1;
	logic       valid_s1;

	// Report stage and held state
	report_t    report_q;
	logic       valid_s2;
	logic [3:0] dpad_mask_q;

	logic       advance;
	logic       take_in;

	// Next-state logic
	report_t    report_nxt;
	logic [3:0] dpad_nxt;
	logic       pressed;
	logic       is_key;
	logic       is_abs;
	logic       dpad_hit;
	logic [3:0] dpad_bit;
	btn_map_t   btn;
	logic       btn_hit;
	logic [BUTTON_COUNT-1:0] btn_bit;
	logic [7:0] axis_val;

	// Move an event into the report stage when that stage is empty or draining
	assign advance  = valid_s1 && (!valid_s2 || rpt.ready);
	assign take_in  = evt.valid && evt.ready;
	assign evt.ready = !valid_s1 || advance;

	assign rpt.valid   = valid_s2;
	assign rpt.payload = report_q;

	always_comb begin
		is_key   = (event_s1.kind == KIND_KEY);
		is_abs   = (event_s1.kind == KIND_ABS);
		pressed  = |event_s1.event_value;
		dpad_hit = is_key && (event_s1.event_code[15:2] == DPAD_BASE[15:2]);
		dpad_bit = 4'b0001 << event_s1.event_code[1:0];
		btn      = button_of_offset(event_s1.event_code[3:0]);
		btn_hit  = is_key && btn.hit && (event_s1.event_code[15:4] == BUTTON_BASE[15:4]);
		btn_bit  = BUTTON_COUNT'(1) << btn.idx;
		// Saturate the axis value to eight bits
		axis_val = (|event_s1.event_value[31:8]) ? AXIS_MAX : event_s1.event_value[7:0];

		dpad_nxt   = dpad_mask_q;
		report_nxt = report_q;

		if (dpad_hit) begin
			dpad_nxt = pressed ? (dpad_mask_q | dpad_bit) : (dpad_mask_q & ~dpad_bit);
			report_nxt.hat_position = hat_of_mask(dpad_nxt);
		end
		if (btn_hit) begin
			report_nxt.button_bits = pressed ? (report_q.button_bits | btn_bit)
				: (report_q.button_bits & ~btn_bit);
		end
		if (is_abs) begin
			case (event_s1.event_code)
				ABS_X:   report_nxt.axis_x  = axis_val;
				ABS_Y:   report_nxt.axis_y  = axis_val;
				ABS_RX:  report_nxt.axis_rx = axis_val;
				ABS_RY:  report_nxt.axis_ry = axis_val;
				default: report_nxt = report_q;
			endcase
		end
	end

	// Input register: hold the event until the report stage takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			event_s1 <= evt.payload;
		end
	end

	// Report register and held state: advance only once the last report is gone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2                <= 1'b0;
			dpad_mask_q             <= 4'd0;
			report_q.hat_position   <= HAT_NEUTRAL;
			report_q.button_bits    <= '0;
			report_q.axis_x         <= '0;
			report_q.axis_y         <= '0;
			report_q.axis_rx        <= '0;
			report_q.axis_ry        <= '0;
		end else if (advance) begin
			valid_s2    <= 1'b1;
			dpad_mask_q <= dpad_nxt;
			report_q    <= report_nxt;
		end else if (rpt.ready) begin
			valid_s2    <= 1'b0;
		end
	end

`ifndef SYNTH
	// Hat code always in range
	a_hat_range: assert property (@(posedge clk) disable iff (!arst_n)
		report_q.hat_position <= HAT_NEUTRAL)
		else $error("hat code out of range");

	// Empty direction mask always reports neutral hat
	a_hat_neutral: assert property (@(posedge clk) disable iff (!arst_n)
		(dpad_mask_q == 4'd0) |-> (report_q.hat_position == HAT_NEUTRAL))
		else $error("hat not neutral with empty dpad mask");

	// Held state must not move while a report waits
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rpt.ready) |=> ($stable(dpad_mask_q) && $stable(report_q)))
		else $error("state changed under a stalled report");

	// A refused event implies a pending event in the input stage
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!evt.ready |-> (valid_s1 && valid_s2))
		else $error("input stalled without a pending event");
`endif

endmodule

`default_nettype wire
